[design/fdbs_pkg.sv]
// Package for the finite-difference boundary value solver.
// Types, constants and datapath command codes shared by all modules; no dependencies.
package fdbs_pkg;

   localparam int FDBS_MAX_POINTS  = 64;
   localparam int FDBS_VALUE_WIDTH = 32;
   localparam int FRAC_BITS        = 24;
   localparam int POINT_W          = 6;
   localparam int DATA_W           = 32;
   localparam int ADDR_W           = 5;
   localparam int DIV_NUM_W        = 56;
   localparam int DIV_DEN_W        = 32;

   localparam logic [2:0] REG_LEFT_END       = 3'd0;
   localparam logic [2:0] REG_RIGHT_END      = 3'd1;
   localparam logic [2:0] REG_INTERVAL_COUNT = 3'd2;
   localparam logic [2:0] REG_BOUNDARY_START = 3'd3;
   localparam logic [2:0] REG_BOUNDARY_END   = 3'd4;

   typedef enum logic [4:0] {
      OP_NONE,
      OP_LOAD,
      OP_STEP_START,
      OP_STORE_H,
      OP_MUL_HH,
      OP_MUL_HP,
      OP_MUL_HQ,
      OP_MUL_HR,
      OP_MUL_AC,
      OP_MUL_AD,
      OP_DIV_C_START,
      OP_DIV_D_START,
      OP_STORE_C,
      OP_STORE_D,
      OP_STORE_ZERO,
      OP_BACK_INIT,
      OP_BACK_RD,
      OP_BACK_MUL,
      OP_EMIT_RD,
      OP_EMIT_LD
   } dp_op_type;

   typedef struct packed {
      dp_op_type          op;
      logic [POINT_W-1:0] idx;
      logic               first;
      logic               last;
   } cmd_type;

   typedef struct packed {
      logic div_busy;
      logic b_zero;
      logic rsp_valid;
      logic rsp_taken;
   } stat_type;

endpackage

[design/finite_difference_bvp_solver.sv]
// Top level of the finite-difference boundary value solver: register file and
// controller/datapath. Depends on fdbs_pkg, fdbs_ctrl, fdbs_datapath.
//
//   channel | handshake           | payload
//   req     | req_valid/req_ready | req_coef_p, req_coef_q, req_coef_r
//   rsp     | rsp_valid/rsp_ready | rsp_point_index, rsp_solution_value, rsp_last_point,
//           |                     | rsp_singular
//   csr     | psel/penable/pwrite | paddr, pwdata, prdata (pready tied high)
//
// Each interior point waits on the shared radix-2 divider (56 quotient bits) twice,
// for c and then d, before req_ready returns; the first point of a run also waits on
// the step division, and a zero pivot skips both waits. After the last point, back
// substitution steps through read, multiply and write states for each point, then
// each result is read, loaded and held until rsp takes it. One item is in work at a time.
// Reset is synchronous; registers return to their reset values. No clearing pass.
module finite_difference_bvp_solver #(
   parameter int MAX_POINTS  = fdbs_pkg::FDBS_MAX_POINTS,
   parameter int VALUE_WIDTH = fdbs_pkg::FDBS_VALUE_WIDTH
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic signed [fdbs_pkg::DATA_W-1:0] req_coef_p,
   input  logic signed [fdbs_pkg::DATA_W-1:0] req_coef_q,
   input  logic signed [fdbs_pkg::DATA_W-1:0] req_coef_r,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [fdbs_pkg::POINT_W-1:0]       rsp_point_index,
   output logic signed [fdbs_pkg::DATA_W-1:0] rsp_solution_value,
   output logic                               rsp_last_point,
   output logic                               rsp_singular,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [fdbs_pkg::ADDR_W-1:0]        paddr,
   input  logic [fdbs_pkg::DATA_W-1:0]        pwdata,
   output logic [fdbs_pkg::DATA_W-1:0]        prdata,
   output logic                               pready
);
   import fdbs_pkg::*;

   logic signed [DATA_W-1:0] left_end_ff, right_end_ff, bstart_ff, bend_ff;
   logic [POINT_W-1:0]       count_ff;
   logic [2:0]               reg_idx;
   logic                     wr_en;
   cmd_type                  cmd;
   stat_type                 stat;
   logic [POINT_W-1:0]       n_eff;

   assign reg_idx = paddr[4:2];
   assign pready  = 1'b1;
   assign wr_en   = psel & penable & pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         left_end_ff  <= '0;
         right_end_ff <= DATA_W'(32'h0100_0000);
         count_ff     <= POINT_W'(10);
         bstart_ff    <= '0;
         bend_ff      <= '0;
      end else if (wr_en) begin
         unique case (reg_idx)
            REG_LEFT_END:       left_end_ff  <= pwdata;
            REG_RIGHT_END:      right_end_ff <= pwdata;
            REG_INTERVAL_COUNT: count_ff     <= pwdata[POINT_W-1:0];
            REG_BOUNDARY_START: bstart_ff    <= pwdata;
            REG_BOUNDARY_END:   bend_ff      <= pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_LEFT_END:       prdata = left_end_ff;
         REG_RIGHT_END:      prdata = right_end_ff;
         REG_INTERVAL_COUNT: prdata = DATA_W'(count_ff);
         REG_BOUNDARY_START: prdata = bstart_ff;
         REG_BOUNDARY_END:   prdata = bend_ff;
         default:            prdata = '0;
      endcase
   end

   fdbs_ctrl #(
      .MAX_POINTS (MAX_POINTS)
   ) u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .interval_count (count_ff),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .cmd            (cmd),
      .stat           (stat),
      .n_eff          (n_eff)
   );

   fdbs_datapath #(
      .MAX_POINTS  (MAX_POINTS),
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .stat               (stat),
      .n_eff              (n_eff),
      .left_end           (left_end_ff),
      .right_end          (right_end_ff),
      .boundary_start     (bstart_ff),
      .boundary_end       (bend_ff),
      .coef_p             (req_coef_p),
      .coef_q             (req_coef_q),
      .coef_r             (req_coef_r),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_point_index    (rsp_point_index),
      .rsp_solution_value (rsp_solution_value),
      .rsp_last_point     (rsp_last_point),
      .rsp_singular       (rsp_singular)
   );

endmodule

[design/fdbs_div.sv]
// Iterative restoring divider, one quotient bit per cycle, unsigned magnitudes.
// Uses fdbs_pkg for operand widths.
module fdbs_div (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [fdbs_pkg::DIV_NUM_W-1:0] num_mag,
   input  logic [fdbs_pkg::DIV_DEN_W-1:0] den_mag,
   output logic                           busy,
   output logic [fdbs_pkg::DIV_NUM_W-1:0] quo_mag
);
   import fdbs_pkg::*;

   localparam int CNT_W = $clog2(DIV_NUM_W + 1);

   logic [DIV_NUM_W-1:0] acc_ff;
   logic [DIV_DEN_W-1:0] rem_ff;
   logic [DIV_DEN_W-1:0] den_ff;
   logic [CNT_W-1:0]     cnt_ff;
   logic                 busy_ff;

   logic [DIV_DEN_W:0]   shifted;
   logic [DIV_DEN_W:0]   trial;
   logic                 qbit;

   always_comb begin
      shifted = {rem_ff, acc_ff[DIV_NUM_W-1]};
      trial   = shifted - {1'b0, den_ff};
      qbit    = ~trial[DIV_DEN_W];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= CNT_W'(DIV_NUM_W);
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         acc_ff <= num_mag;
         rem_ff <= '0;
         den_ff <= den_mag;
      end else if (busy_ff) begin
         acc_ff <= {acc_ff[DIV_NUM_W-2:0], qbit};
         rem_ff <= qbit ? trial[DIV_DEN_W-1:0] : shifted[DIV_DEN_W-1:0];
      end
   end

   assign busy    = busy_ff;
   assign quo_mag = acc_ff;

endmodule

[design/fdbs_datapath.sv]
// Datapath: shared multiplier, divider, row registers, sweep and solution memories,
// output register. Depends on fdbs_pkg and fdbs_div.
module fdbs_datapath #(
   parameter int MAX_POINTS  = fdbs_pkg::FDBS_MAX_POINTS,
   parameter int VALUE_WIDTH = fdbs_pkg::FDBS_VALUE_WIDTH
) (
   input  logic                                clock,
   input  logic                                reset,
   input  fdbs_pkg::cmd_type                   cmd,
   output fdbs_pkg::stat_type                  stat,
   input  logic [fdbs_pkg::POINT_W-1:0]        n_eff,
   input  logic signed [fdbs_pkg::DATA_W-1:0]  left_end,
   input  logic signed [fdbs_pkg::DATA_W-1:0]  right_end,
   input  logic signed [fdbs_pkg::DATA_W-1:0]  boundary_start,
   input  logic signed [fdbs_pkg::DATA_W-1:0]  boundary_end,
   input  logic signed [fdbs_pkg::DATA_W-1:0]  coef_p,
   input  logic signed [fdbs_pkg::DATA_W-1:0]  coef_q,
   input  logic signed [fdbs_pkg::DATA_W-1:0]  coef_r,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [fdbs_pkg::POINT_W-1:0]        rsp_point_index,
   output logic signed [fdbs_pkg::DATA_W-1:0]  rsp_solution_value,
   output logic                                rsp_last_point,
   output logic                                rsp_singular
);
   import fdbs_pkg::*;

   localparam int IDX_W = $clog2(MAX_POINTS);
   localparam int SAT_W = (VALUE_WIDTH > 32) ? 32 : VALUE_WIDTH;
   localparam logic signed [63:0] SAT_HI = (64'sd1 <<< (SAT_W - 1)) - 64'sd1;
   localparam logic signed [63:0] SAT_LO = -SAT_HI - 64'sd1;
   localparam logic signed [63:0] ONE_Q  = 64'sd1 <<< FRAC_BITS;

   function automatic logic signed [DATA_W-1:0] sat64(input logic signed [63:0] v);
      logic signed [63:0] t;
      if (v > SAT_HI) t = SAT_HI;
      else if (v < SAT_LO) t = SAT_LO;
      else t = v;
      return DATA_W'(t);
   endfunction

   logic signed [DATA_W-1:0] p_ff, q_ff, r_ff;
   logic signed [DATA_W-1:0] h_ff, hh_ff, a_ff, b_ff, c_ff, d_ff, y_ff;
   logic signed [DATA_W-1:0] ur_rd_ff, rhs_rd_ff, y_rd_ff;
   logic signed [63:0]       prod_ff;
   dp_op_type                op_d_ff;
   logic [IDX_W-1:0]         idx_d_ff;
   logic                     first_ff;
   logic                     pivot_ff;
   logic                     div_neg_ff;
   logic                     rsp_valid_ff;
   logic [POINT_W-1:0]       rsp_index_ff;
   logic signed [DATA_W-1:0] rsp_value_ff;
   logic                     rsp_last_ff;
   logic                     rsp_sing_ff;

   logic signed [DATA_W-1:0] ur_mem  [MAX_POINTS];
   logic signed [DATA_W-1:0] rhs_mem [MAX_POINTS];
   logic signed [DATA_W-1:0] y_mem   [MAX_POINTS];

   logic [IDX_W-1:0]         addr;
   logic signed [DATA_W-1:0] mx, my;
   logic signed [DATA_W-1:0] qm, half, cprev, dprev, y_new, qval;
   logic signed [63:0]       diff, cmag, dmag, bmag, qs;
   logic                     div_start, div_busy, div_neg;
   logic [DIV_NUM_W-1:0]     div_num, quo_mag;
   logic [DIV_DEN_W-1:0]     div_den;

   assign addr = cmd.idx[IDX_W-1:0];

   always_comb begin
      unique case (cmd.op)
         OP_MUL_HH:   begin mx = h_ff;     my = h_ff;  end
         OP_MUL_HP:   begin mx = h_ff;     my = p_ff;  end
         OP_MUL_HQ:   begin mx = hh_ff;    my = q_ff;  end
         OP_MUL_HR:   begin mx = hh_ff;    my = r_ff;  end
         OP_MUL_AC:   begin mx = a_ff;     my = cprev; end
         OP_MUL_AD:   begin mx = a_ff;     my = dprev; end
         OP_BACK_MUL: begin mx = ur_rd_ff; my = y_ff;  end
         default:     begin mx = '0;       my = '0;    end
      endcase
   end

   always_comb begin
      qm    = sat64(prod_ff >>> FRAC_BITS);
      half  = qm >>> 1;
      cprev = first_ff ? '0 : ur_rd_ff;
      dprev = first_ff ? boundary_start : rhs_rd_ff;
      y_new = sat64(64'(rhs_rd_ff) - 64'(qm));
      qs    = div_neg_ff ? -$signed({8'd0, quo_mag}) : $signed({8'd0, quo_mag});
      qval  = sat64(qs);
   end

   // divider operand setup, sign-magnitude
   always_comb begin
      diff = 64'(right_end) - 64'(left_end);
      cmag = c_ff[DATA_W-1] ? -64'(c_ff) : 64'(c_ff);
      dmag = d_ff[DATA_W-1] ? -64'(d_ff) : 64'(d_ff);
      bmag = b_ff[DATA_W-1] ? -64'(b_ff) : 64'(b_ff);
      div_start = 1'b1;
      unique case (cmd.op)
         OP_STEP_START: begin
            div_neg = diff[63];
            div_num = DIV_NUM_W'(diff[63] ? -diff : diff);
            div_den = DIV_DEN_W'(n_eff);
         end
         OP_DIV_C_START: begin
            div_neg = c_ff[DATA_W-1] ^ b_ff[DATA_W-1];
            div_num = DIV_NUM_W'(cmag <<< FRAC_BITS);
            div_den = DIV_DEN_W'(bmag);
         end
         OP_DIV_D_START: begin
            div_neg = d_ff[DATA_W-1] ^ b_ff[DATA_W-1];
            div_num = DIV_NUM_W'(dmag <<< FRAC_BITS);
            div_den = DIV_DEN_W'(bmag);
         end
         default: begin
            div_start = 1'b0;
            div_neg   = 1'b0;
            div_num   = '0;
            div_den   = '0;
         end
      endcase
   end

   fdbs_div u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start),
      .num_mag (div_num),
      .den_mag (div_den),
      .busy    (div_busy),
      .quo_mag (quo_mag)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         op_d_ff  <= OP_NONE;
         pivot_ff <= 1'b0;
      end else begin
         op_d_ff <= cmd.op;
         if (cmd.op == OP_LOAD && cmd.first) begin
            pivot_ff <= 1'b0;
         end else if (cmd.op == OP_STORE_ZERO) begin
            pivot_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      prod_ff  <= mx * my;
      idx_d_ff <= addr;
      if (div_start) begin
         div_neg_ff <= div_neg;
      end
      unique case (cmd.op)
         OP_LOAD: begin
            p_ff     <= coef_p;
            q_ff     <= coef_q;
            r_ff     <= coef_r;
            first_ff <= cmd.first;
         end
         OP_STORE_H:   h_ff <= qval;
         OP_BACK_INIT: y_ff <= boundary_end;
         default: ;
      endcase
      // second stage of the multiplier
      unique case (op_d_ff)
         OP_MUL_HH: hh_ff <= qm;
         OP_MUL_HP: begin
            a_ff <= sat64(ONE_Q - 64'(half));
            c_ff <= sat64(ONE_Q + 64'(half));
         end
         OP_MUL_HQ:   b_ff <= sat64(64'(qm) - (ONE_Q <<< 1));
         OP_MUL_HR:   d_ff <= qm;
         OP_MUL_AC:   b_ff <= sat64(64'(b_ff) - 64'(qm));
         OP_MUL_AD:   d_ff <= sat64(64'(d_ff) - 64'(qm));
         OP_BACK_MUL: y_ff <= y_new;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.op == OP_STORE_C) begin
         ur_mem[addr] <= qval;
      end else if (cmd.op == OP_STORE_ZERO) begin
         ur_mem[addr] <= '0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op == OP_STORE_D) begin
         rhs_mem[addr] <= qval;
      end else if (cmd.op == OP_STORE_ZERO) begin
         rhs_mem[addr] <= '0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op == OP_LOAD || cmd.op == OP_BACK_RD) begin
         ur_rd_ff  <= ur_mem[addr];
         rhs_rd_ff <= rhs_mem[addr];
      end
   end

   always_ff @(posedge clock) begin
      if (op_d_ff == OP_BACK_MUL) begin
         y_mem[idx_d_ff] <= y_new;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op == OP_EMIT_RD) begin
         y_rd_ff <= y_mem[addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.op == OP_EMIT_LD) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op == OP_EMIT_LD) begin
         rsp_index_ff <= cmd.idx;
         rsp_last_ff  <= cmd.last;
         rsp_sing_ff  <= pivot_ff;
         priority if (cmd.first) rsp_value_ff <= boundary_start;
         else if (cmd.last)      rsp_value_ff <= boundary_end;
         else                    rsp_value_ff <= y_rd_ff;
      end
   end

   assign stat.div_busy  = div_busy;
   assign stat.b_zero    = (b_ff == '0);
   assign stat.rsp_valid = rsp_valid_ff;
   assign stat.rsp_taken = rsp_valid_ff & rsp_ready;

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_point_index    = rsp_index_ff;
   assign rsp_solution_value = rsp_value_ff;
   assign rsp_last_point     = rsp_last_ff;
   assign rsp_singular       = rsp_sing_ff;

endmodule

[design/fdbs_ctrl.sv]
// Controller: sequences row build, forward sweep, back substitution and emission.
// Drives the datapath by cmd_type; depends on fdbs_pkg.
module fdbs_ctrl #(
   parameter int MAX_POINTS = fdbs_pkg::FDBS_MAX_POINTS
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [fdbs_pkg::POINT_W-1:0] interval_count,
   input  logic                         req_valid,
   output logic                         req_ready,
   output fdbs_pkg::cmd_type            cmd,
   input  fdbs_pkg::stat_type           stat,
   output logic [fdbs_pkg::POINT_W-1:0] n_eff
);
   import fdbs_pkg::*;

   localparam int IDX_W = $clog2(MAX_POINTS);
   localparam logic [POINT_W:0] NMAX     = (POINT_W + 1)'(MAX_POINTS - 1);
   localparam logic [IDX_W-1:0] KMAX     = IDX_W'(MAX_POINTS - 1);

   typedef enum logic [15:0] {
      S_IDLE       = 16'h0001,
      S_STEP       = 16'h0002,
      S_STEP_WAIT  = 16'h0004,
      S_MUL        = 16'h0008,
      S_MUL_END    = 16'h0010,
      S_DIV_C      = 16'h0020,
      S_DIV_C_WAIT = 16'h0040,
      S_DIV_D      = 16'h0080,
      S_DIV_D_WAIT = 16'h0100,
      S_NEXT       = 16'h0200,
      S_BACK_RD    = 16'h0400,
      S_BACK_MUL   = 16'h0800,
      S_BACK_WR    = 16'h1000,
      S_EMIT_RD    = 16'h2000,
      S_EMIT_LD    = 16'h4000,
      S_EMIT_WAIT  = 16'h8000
   } state_type;

   state_type        state_ff, state_in;
   logic [IDX_W-1:0] pr_ff, pr_in;
   logic [IDX_W-1:0] k_ff, k_in;
   logic [IDX_W-1:0] cnt_ff, cnt_in;
   logic [2:0]       mcnt_ff, mcnt_in;
   logic [IDX_W-1:0] n_idx, k_now;
   logic [POINT_W:0] nraw;

   always_comb begin
      nraw = {1'b0, interval_count};
      priority if (nraw < (POINT_W + 1)'(2)) n_idx = IDX_W'(2);
      else if (nraw > NMAX)                 n_idx = KMAX;
      else                                  n_idx = nraw[IDX_W-1:0];
      k_now = (pr_ff == KMAX) ? KMAX : pr_ff + 1'b1;
   end

   assign n_eff     = POINT_W'(n_idx);
   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in  = state_ff;
      pr_in     = pr_ff;
      k_in      = k_ff;
      cnt_in    = cnt_ff;
      mcnt_in   = mcnt_ff;
      cmd.op    = OP_NONE;
      cmd.idx   = '0;
      cmd.first = 1'b0;
      cmd.last  = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.op    = OP_LOAD;
               cmd.idx   = POINT_W'(k_now - 1'b1);
               cmd.first = (pr_ff == '0);
               k_in      = k_now;
               mcnt_in   = '0;
               state_in  = (pr_ff == '0) ? S_STEP : S_MUL;
            end
         end
         S_STEP: begin
            cmd.op   = OP_STEP_START;
            state_in = S_STEP_WAIT;
         end
         S_STEP_WAIT: begin
            if (!stat.div_busy) begin
               cmd.op   = OP_STORE_H;
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            unique case (mcnt_ff)
               3'd0:    cmd.op = OP_MUL_HH;
               3'd1:    cmd.op = OP_MUL_HP;
               3'd2:    cmd.op = OP_MUL_HQ;
               3'd3:    cmd.op = OP_MUL_HR;
               3'd4:    cmd.op = OP_MUL_AC;
               3'd5:    cmd.op = OP_MUL_AD;
               default: cmd.op = OP_NONE;
            endcase
            mcnt_in = mcnt_ff + 1'b1;
            if (mcnt_ff == 3'd5) begin
               state_in = S_MUL_END;
            end
         end
         S_MUL_END: state_in = S_DIV_C;
         S_DIV_C: begin
            cmd.idx = POINT_W'(k_ff);
            if (stat.b_zero) begin
               cmd.op   = OP_STORE_ZERO;
               state_in = S_NEXT;
            end else begin
               cmd.op   = OP_DIV_C_START;
               state_in = S_DIV_C_WAIT;
            end
         end
         S_DIV_C_WAIT: begin
            cmd.idx = POINT_W'(k_ff);
            if (!stat.div_busy) begin
               cmd.op   = OP_STORE_C;
               state_in = S_DIV_D;
            end
         end
         S_DIV_D: begin
            cmd.op   = OP_DIV_D_START;
            state_in = S_DIV_D_WAIT;
         end
         S_DIV_D_WAIT: begin
            cmd.idx = POINT_W'(k_ff);
            if (!stat.div_busy) begin
               cmd.op   = OP_STORE_D;
               state_in = S_NEXT;
            end
         end
         S_NEXT: begin
            pr_in = k_ff;
            if (k_ff >= n_idx - 1'b1) begin
               cmd.op   = OP_BACK_INIT;
               cnt_in   = n_idx - 1'b1;
               state_in = S_BACK_RD;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_BACK_RD: begin
            cmd.op   = OP_BACK_RD;
            cmd.idx  = POINT_W'(cnt_ff);
            state_in = S_BACK_MUL;
         end
         S_BACK_MUL: begin
            cmd.op   = OP_BACK_MUL;
            cmd.idx  = POINT_W'(cnt_ff);
            state_in = S_BACK_WR;
         end
         S_BACK_WR: begin
            if (cnt_ff == IDX_W'(1)) begin
               cnt_in   = '0;
               state_in = S_EMIT_RD;
            end else begin
               cnt_in   = cnt_ff - 1'b1;
               state_in = S_BACK_RD;
            end
         end
         S_EMIT_RD: begin
            cmd.op   = OP_EMIT_RD;
            cmd.idx  = POINT_W'(cnt_ff);
            state_in = S_EMIT_LD;
         end
         S_EMIT_LD: begin
            cmd.op    = OP_EMIT_LD;
            cmd.idx   = POINT_W'(cnt_ff);
            cmd.first = (cnt_ff == '0);
            cmd.last  = (cnt_ff == n_idx);
            state_in  = S_EMIT_WAIT;
         end
         S_EMIT_WAIT: begin
            if (stat.rsp_taken) begin
               if (cnt_ff == n_idx) begin
                  pr_in    = '0;
                  state_in = S_IDLE;
               end else begin
                  cnt_in   = cnt_ff + 1'b1;
                  state_in = S_EMIT_RD;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         pr_ff    <= '0;
         k_ff     <= '0;
         cnt_ff   <= '0;
         mcnt_ff  <= '0;
      end else begin
         state_ff <= state_in;
         pr_ff    <= pr_in;
         k_ff     <= k_in;
         cnt_ff   <= cnt_in;
         mcnt_ff  <= mcnt_in;
      end
   end

   // no new item while a result transfer is pending
   a_no_accept_during_rsp: assert property (@(posedge clock) disable iff (reset)
      stat.rsp_valid |-> !req_ready)
      else $error("item accepted while result pending");

   // divider is never restarted while it runs
   a_div_idle_on_start: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_DIV_C_START || cmd.op == OP_DIV_D_START || cmd.op == OP_STEP_START)
      |-> !stat.div_busy)
      else $error("divider started while busy");

   // a loaded result is held until taken
   a_emit_wait_valid: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_EMIT_WAIT |-> stat.rsp_valid)
      else $error("waiting on a result that is not valid");

endmodule
